// ----- design/pht_pkg.sv -----
`default_nettype none

package pht_pkg;

  localparam int SLOTS_DEF     = 1024;
  localparam int SLOT_BITS_DEF = 10;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_RUN    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    mode_e       mode;
    logic [31:0] handle;
    logic [9:0]  slot;
    logic        check_owner;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        slot_valid;
    logic [9:0]  slot_out;
    logic [31:0] handle_out;
    logic [31:0] runs_out;
  } out_item_t;

endpackage

`default_nettype wire

// ----- design/pht_ram.sv -----
`default_nettype none

module pht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/process_handle_table_unit.sv -----
// Process handle table with a LIFO free list and generation-tagged handles.
//
// Input channel: in_item_i with in_valid_i / in_stall_o. Output channel:
// out_item_o with out_valid_o / out_stall_i. An item moves at a rising edge
// with valid high and stall low. Every input item gives exactly one result.
//
// All slot state sits in one single-port-read, single-port-write RAM word
// per slot (use flag, free link, handle, parent, run count). An item is read
// in the cycle it is accepted, then checked and written back, and its result
// is registered once the output register is free. A checked lookup whose
// handle matches adds a parent-chain walk of up to SLOTS+1 steps, each step
// that goes on to the parent one RAM read.
//
// Reset empties the table at once: a fill mark tracks how many slots have
// ever been touched, and words at or above it read as free with their default
// free link, so no clearing pass is needed and items are taken straight away.
// While the receiver stalls the result is held; one further item is taken
// and worked through, and it then waits before write-back until the output
// register frees.
`default_nettype none

module process_handle_table_unit #(
  parameter int SLOTS     = pht_pkg::SLOTS_DEF,
  parameter int SLOT_BITS = pht_pkg::SLOT_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pht_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output pht_pkg::out_item_t       out_item_o
);

  localparam int AW = $clog2(SLOTS);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int GS = SLOT_BITS + 1;
  localparam int GW = 32 - SLOT_BITS - 1;

  typedef struct packed {
    logic          in_use;
    logic [NW-1:0] free_next;
    logic [31:0]   handle;
    logic [31:0]   parent;
    logic [31:0]   runs;
  } word_t;

  localparam int WW = $bits(word_t);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_WALK = 3'b100
  } state_e;

  state_e             state_q, state_d;
  pht_pkg::in_item_t  item_q;
  logic [AW-1:0]      addr_q;
  logic               hit_q;
  logic [NW-1:0]      head_q, head_d;
  logic [NW-1:0]      mark_q, mark_d;
  logic [GW-1:0]      gen_q, gen_d;
  logic               cur_valid_q, cur_valid_d;
  logic [AW-1:0]      cur_slot_q, cur_slot_d;
  pht_pkg::out_item_t res_q, res_d;
  logic [SLOT_BITS-1:0] wk_idx_q, wk_idx_d;
  logic [NW-1:0]      wk_cnt_q, wk_cnt_d;
  logic               wk_first_q, wk_first_d;
  logic               out_valid_q, out_valid_d;
  pht_pkg::out_item_t out_q, out_d;

  logic               in_acc;
  logic               out_free;
  logic [AW-1:0]      acc_addr;
  logic               acc_hit;
  logic [31:0]        hidx32;
  logic [31:0]        slot32;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  word_t              mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [WW-1:0]      mem_rdata;
  word_t              w;

  logic               untouched;
  logic               in_use_e;
  logic [NW-1:0]      nxt_e;
  logic [GW-1:0]      gen_nx;
  logic [31:0]        new_handle;
  pht_pkg::out_item_t ok_out;

  logic [SLOT_BITS-1:0] wk_cur;
  logic [31:0]        wk_cur32;
  logic               wk_done;
  logic               wk_ok;
  logic               wk_cont;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign w          = word_t'(mem_rdata);

  // Read address for the item being accepted
  assign hidx32 = 32'(in_item_i.handle[SLOT_BITS-1:0]);
  assign slot32 = 32'(in_item_i.slot);

  always_comb begin
    acc_addr = '0;
    acc_hit  = 1'b0;
    unique case (in_item_i.mode)
      pht_pkg::MODE_ALLOC: begin
        acc_addr = head_q[AW-1:0];
        acc_hit  = (32'(head_q) < 32'(SLOTS));
      end
      pht_pkg::MODE_LOOKUP: begin
        if (in_item_i.handle == 32'd0) begin
          acc_addr = cur_slot_q;
          acc_hit  = cur_valid_q;
        end else begin
          acc_addr = hidx32[AW-1:0];
          acc_hit  = (hidx32 < 32'(SLOTS));
        end
      end
      pht_pkg::MODE_FREE, pht_pkg::MODE_RUN: begin
        acc_addr = slot32[AW-1:0];
        acc_hit  = (slot32 < 32'(SLOTS));
      end
    endcase
  end

  // Words at or above the fill mark were never written: free, default link
  assign untouched = (32'(addr_q) >= 32'(mark_q));
  assign in_use_e  = !untouched && w.in_use;
  assign nxt_e     = untouched ? NW'(32'(addr_q) + 32'd1) : w.free_next;
  assign gen_nx    = gen_q + GW'(1);
  assign new_handle = (32'(gen_nx) << GS) | 32'(addr_q);

  always_comb begin
    ok_out            = '0;
    ok_out.status     = pht_pkg::STATUS_OK;
    ok_out.slot_valid = 1'b1;
    ok_out.slot_out   = 10'(addr_q);
    ok_out.handle_out = w.handle;
    ok_out.runs_out   = w.runs;
  end

  // Parent-chain walk, one RAM read for each step that goes on
  assign wk_cur   = wk_first_q ? wk_idx_q : w.parent[SLOT_BITS-1:0];
  assign wk_cur32 = 32'(wk_cur);

  always_comb begin
    wk_done = 1'b1;
    wk_ok   = 1'b0;
    wk_cont = 1'b0;
    priority if (wk_cur32 >= 32'(SLOTS)) begin
      wk_ok = 1'b0;
    end else if (cur_valid_q && (wk_cur32 == 32'(cur_slot_q))) begin
      wk_ok = 1'b1;
    end else if (wk_cur32 == 32'd0) begin
      wk_ok = 1'b0;
    end else if (wk_cnt_q == NW'(SLOTS)) begin
      wk_ok = 1'b0;
    end else begin
      wk_done = 1'b0;
      wk_cont = (state_q == S_WALK);
    end
  end

  assign mem_re    = in_acc || wk_cont;
  assign mem_raddr = in_acc ? acc_addr : wk_cur32[AW-1:0];

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    mark_d      = mark_q;
    gen_d       = gen_q;
    cur_valid_d = cur_valid_q;
    cur_slot_d  = cur_slot_q;
    res_d       = res_q;
    wk_idx_d    = wk_idx_q;
    wk_cnt_d    = wk_cnt_q;
    wk_first_d  = wk_first_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = w;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        if (item_q.mode == pht_pkg::MODE_LOOKUP && item_q.handle != 32'd0 &&
            hit_q && in_use_e && w.handle == item_q.handle && item_q.check_owner) begin
          // Hold the result and start the walk at the handle's own slot
          res_d      = ok_out;
          wk_idx_d   = item_q.handle[SLOT_BITS-1:0];
          wk_cnt_d   = '0;
          wk_first_d = 1'b1;
          state_d    = S_WALK;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '0;
          out_d.status = pht_pkg::STATUS_BAD;
          state_d     = S_IDLE;
          unique case (item_q.mode)
            pht_pkg::MODE_ALLOC: begin
              if (!hit_q) begin
                out_d.status = pht_pkg::STATUS_FULL;
              end else begin
                gen_d            = gen_nx;
                head_d           = nxt_e;
                mem_we           = 1'b1;
                mem_wdata.in_use = 1'b1;
                mem_wdata.free_next = nxt_e;
                mem_wdata.handle = new_handle;
                mem_wdata.parent = item_q.handle;
                mem_wdata.runs   = '0;
                if (untouched) begin
                  mark_d = mark_q + NW'(1);
                end
                out_d            = ok_out;
                out_d.handle_out = new_handle;
                out_d.runs_out   = '0;
              end
            end
            pht_pkg::MODE_LOOKUP: begin
              if (item_q.handle == 32'd0) begin
                if (hit_q) begin
                  out_d = ok_out;
                end else begin
                  out_d.status = pht_pkg::STATUS_OK;
                end
              end else if (hit_q && in_use_e && w.handle == item_q.handle) begin
                out_d = ok_out;
              end
            end
            pht_pkg::MODE_FREE: begin
              if (hit_q && in_use_e) begin
                mem_we              = 1'b1;
                mem_wdata.in_use    = 1'b0;
                mem_wdata.free_next = head_q;
                head_d              = NW'(addr_q);
                out_d               = ok_out;
              end
            end
            pht_pkg::MODE_RUN: begin
              if (hit_q && in_use_e) begin
                mem_we         = 1'b1;
                mem_wdata.runs = w.runs + 32'd1;
                cur_valid_d    = 1'b1;
                cur_slot_d     = addr_q;
                out_d          = ok_out;
                out_d.runs_out = w.runs + 32'd1;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        if (wk_cont) begin
          wk_first_d = 1'b0;
          wk_cnt_d   = wk_cnt_q + NW'(1);
        end else if (wk_done && out_free) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
          if (wk_ok) begin
            out_d = res_q;
          end else begin
            out_d        = '0;
            out_d.status = pht_pkg::STATUS_BAD;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      mark_q      <= '0;
      gen_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_slot_q  <= '0;
      wk_first_q  <= 1'b0;
      wk_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      mark_q      <= mark_d;
      gen_q       <= gen_d;
      cur_valid_q <= cur_valid_d;
      cur_slot_q  <= cur_slot_d;
      wk_first_q  <= wk_first_d;
      wk_cnt_q    <= wk_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item_i;
      addr_q <= acc_addr;
      hit_q  <= acc_hit;
    end
    res_q    <= res_d;
    wk_idx_q <= wk_idx_d;
    out_q    <= out_d;
  end

  pht_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_head_below_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= mark_q)
    else $error("free list head beyond fill mark");

  a_cur_touched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (32'(cur_slot_q) < 32'(mark_q)))
    else $error("current slot never allocated");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_EVAL))
    else $error("accepted item not evaluated next cycle");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (32'(wk_cnt_q) <= 32'(SLOTS)))
    else $error("parent walk exceeded its bound");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status != pht_pkg::STATUS_OK) |->
      (!out_q.slot_valid && out_q.handle_out == 32'd0 && out_q.runs_out == 32'd0))
    else $error("error result carries slot data");
`endif

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none

module tb;
  import pht_pkg::*;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int SLOT_BITS = SLOT_BITS_DEF;
  localparam int GEN_W     = 32 - SLOT_BITS - 1;

  typedef struct {
    in_item_t  item;
    out_item_t want;
  } job_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // shadow of the table
  bit          tbl_used    [SLOTS];
  bit          tbl_written [SLOTS];
  logic [31:0] tbl_handle  [SLOTS];
  logic [31:0] tbl_parent  [SLOTS];
  logic [31:0] tbl_runs    [SLOTS];
  int          free_link   [SLOTS];
  int          free_head;
  logic [GEN_W-1:0] gen_count;
  bit          cur_valid;
  int          cur_slot;
  int          ever_q[$];

  job_t      pending_q[$];
  out_item_t awaited_q[$];
  out_item_t held_want;
  int        sent_cnt = 0;
  int        got_cnt = 0;
  int        errors = 0;

  process_handle_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic void table_reset();
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i]    = 1'b0;
      tbl_written[i] = 1'b0;
      tbl_handle[i]  = '0;
      tbl_parent[i]  = '0;
      tbl_runs[i]    = '0;
      free_link[i]   = i + 1;
    end
    free_head = 0;
    gen_count = '0;
    cur_valid = 1'b0;
    cur_slot  = 0;
  endfunction

  function automatic out_item_t slot_result(int s);
    out_item_t r;
    r.status     = STATUS_OK;
    r.slot_valid = 1'b1;
    r.slot_out   = s[SLOT_BITS-1:0];
    r.handle_out = tbl_handle[s];
    r.runs_out   = tbl_runs[s];
    return r;
  endfunction

  function automatic out_item_t error_result(status_e st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic bit chain_reaches_current(logic [31:0] h);
    int idx;
    idx = int'(h[SLOT_BITS-1:0]);
    for (int n = 0; n <= SLOTS; n++) begin
      if (cur_valid && idx == cur_slot) return 1'b1;
      if (idx == 0) return 1'b0;
      idx = int'(tbl_parent[idx][SLOT_BITS-1:0]);
    end
    return 1'b0;
  endfunction

  // a walk must never read the parent of a slot that was never allocated
  function automatic bit walk_defined(logic [31:0] h);
    int idx;
    idx = int'(h[SLOT_BITS-1:0]);
    for (int n = 0; n <= SLOTS; n++) begin
      if (cur_valid && idx == cur_slot) return 1'b1;
      if (idx == 0) return 1'b1;
      if (!tbl_written[idx]) return 1'b0;
      idx = int'(tbl_parent[idx][SLOT_BITS-1:0]);
    end
    return 1'b1;
  endfunction

  function automatic out_item_t table_step(in_item_t it);
    int idx;
    idx = int'(it.slot);
    case (it.mode)
      MODE_ALLOC: begin
        if (free_head >= SLOTS) return error_result(STATUS_FULL);
        idx       = free_head;
        free_head = free_link[idx];
        gen_count = gen_count + 1'b1;
        tbl_handle[idx] = (32'(gen_count) << (SLOT_BITS + 1)) | 32'(idx);
        tbl_parent[idx] = it.handle;
        tbl_runs[idx]   = '0;
        tbl_used[idx]   = 1'b1;
        if (!tbl_written[idx]) ever_q.push_back(idx);
        tbl_written[idx] = 1'b1;
        return slot_result(idx);
      end
      MODE_LOOKUP: begin
        if (it.handle == '0) begin
          if (!cur_valid) return error_result(STATUS_OK);
          return slot_result(cur_slot);
        end
        idx = int'(it.handle[SLOT_BITS-1:0]);
        if (!tbl_used[idx] || tbl_handle[idx] != it.handle) return error_result(STATUS_BAD);
        if (it.check_owner && !chain_reaches_current(it.handle))
          return error_result(STATUS_BAD);
        return slot_result(idx);
      end
      MODE_FREE: begin
        if (!tbl_used[idx]) return error_result(STATUS_BAD);
        tbl_used[idx]  = 1'b0;
        free_link[idx] = free_head;
        free_head      = idx;
        return slot_result(idx);
      end
      default: begin
        if (!tbl_used[idx]) return error_result(STATUS_BAD);
        cur_valid     = 1'b1;
        cur_slot      = idx;
        tbl_runs[idx] = tbl_runs[idx] + 1;
        return slot_result(idx);
      end
    endcase
  endfunction

  function automatic in_item_t make_item(mode_e m, logic [31:0] h, int s, bit chk);
    in_item_t it;
    it.mode        = m;
    it.handle      = h;
    it.slot        = s[SLOT_BITS-1:0];
    it.check_owner = chk;
    return it;
  endfunction

  function automatic int pick_slot();
    int s;
    s = $urandom_range(SLOTS - 1);
    if (ever_q.size() != 0)
      for (int k = 0; k < 16; k++) begin
        s = ever_q[$urandom_range(ever_q.size() - 1)];
        if (tbl_used[s]) break;
      end
    return s;
  endfunction

  function automatic in_item_t random_item(int alloc_pct, int free_pct, int run_pct);
    in_item_t it;
    int roll;
    int pick;
    it.handle      = $urandom();
    it.slot        = SLOT_BITS'($urandom_range(SLOTS - 1));
    it.check_owner = 1'($urandom_range(1));
    roll = $urandom_range(99);
    pick = $urandom_range(99);
    if (roll < alloc_pct) begin
      it.mode = MODE_ALLOC;
      if (pick < 50) it.handle = tbl_handle[pick_slot()];
      else if (pick < 70) it.handle = '0;
    end else if (roll < alloc_pct + free_pct) begin
      it.mode = MODE_FREE;
      if (pick < 75) it.slot = SLOT_BITS'(pick_slot());
    end else if (roll < alloc_pct + free_pct + run_pct) begin
      it.mode = MODE_RUN;
      if (pick < 75) it.slot = SLOT_BITS'(pick_slot());
    end else begin
      it.mode = MODE_LOOKUP;
      if (pick < 15) it.handle = '0;
      else if (pick < 70) it.handle = tbl_handle[pick_slot()];
      else if (pick < 85) it.handle = tbl_handle[pick_slot()] ^ (32'd1 << $urandom_range(31));
    end
    return it;
  endfunction

  task automatic push_item(in_item_t it);
    job_t j;
    if (it.mode == MODE_LOOKUP && it.check_owner && !walk_defined(it.handle))
      it.check_owner = 1'b0;
    j.item = it;
    j.want = table_step(it);
    pending_q.push_back(j);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || in_valid || awaited_q.size() != 0)
      @(negedge clk_i);
  endtask

  function automatic bit idle_roll(int n);
    if (n >= 500 && n < 800) return 1'b0;
    return $urandom_range(99) < 24;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else begin
      if (in_valid && in_stall == 1'b0) begin
        awaited_q.push_back(held_want);
        sent_cnt++;
      end
      if (!in_valid || in_stall == 1'b0) begin
        if (pending_q.size() != 0 && !idle_roll(sent_cnt)) begin
          in_valid  <= 1'b1;
          in_item   <= pending_q[0].item;
          held_want = pending_q[0].want;
          void'(pending_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall <= 1'b0;
    else out_stall <= idle_roll(got_cnt);
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid === 1'b1 && out_stall == 1'b0) begin
      got_cnt++;
      if (awaited_q.size() == 0) begin
        $display("%0t unexpected item: expected none, got %p", $time, out_item);
        errors++;
      end else begin
        want = awaited_q.pop_front();
        compare_field("status", 32'(want.status), 32'(out_item.status));
        compare_field("slot_valid", 32'(want.slot_valid), 32'(out_item.slot_valid));
        compare_field("slot_out", 32'(want.slot_out), 32'(out_item.slot_out));
        compare_field("handle_out", want.handle_out, out_item.handle_out);
        compare_field("runs_out", want.runs_out, out_item.runs_out);
      end
    end
  end

  initial begin
    table_reset();
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    push_item(make_item(MODE_LOOKUP, 32'h0, 0, 1'b1));        // no current slot yet
    push_item(make_item(MODE_RUN, 32'hFFFF_FFFF, 5, 1'b0));   // free slot
    push_item(make_item(MODE_FREE, 32'h0, SLOTS - 1, 1'b1));
    push_item(make_item(MODE_ALLOC, 32'h0, 0, 1'b0));
    push_item(make_item(MODE_ALLOC, tbl_handle[0], 0, 1'b0));
    push_item(make_item(MODE_ALLOC, 32'hFFFF_F803, 0, 1'b0));
    push_item(make_item(MODE_ALLOC, 32'h5555_5402, 0, 1'b0)); // closes a parent loop
    push_item(make_item(MODE_ALLOC, tbl_handle[1], 0, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[4], 0, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[4], 0, 1'b1)); // walk ends at slot zero
    push_item(make_item(MODE_RUN, 32'h0, 1, 1'b0));
    push_item(make_item(MODE_LOOKUP, 32'h0, 0, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[4], 0, 1'b1));
    push_item(make_item(MODE_LOOKUP, tbl_handle[2], 0, 1'b1)); // loop, bounded walk
    push_item(make_item(MODE_LOOKUP, tbl_handle[4] ^ 32'h0010_0000, 0, 1'b0));
    push_item(make_item(MODE_FREE, 32'h0, 1, 1'b0));           // current slot freed
    push_item(make_item(MODE_LOOKUP, 32'h0, 0, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[4], 0, 1'b1));
    push_item(make_item(MODE_RUN, 32'h0, 1, 1'b0));
    push_item(make_item(MODE_FREE, 32'h0, 1, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[1], 0, 1'b0));
    push_item(make_item(MODE_RUN, 32'h0, 4, 1'b0));
    push_item(make_item(MODE_LOOKUP, tbl_handle[4], 0, 1'b1));
    push_item(make_item(MODE_ALLOC, 32'hFFFF_FFFF, 0, 1'b0));  // reuses slot 1
    push_item(make_item(MODE_LOOKUP, 32'hFFFF_FFFF, 0, 1'b1));
    wait_drained();

    repeat (150) push_item(random_item(40, 15, 8));
    // fill the table, then hammer it while full
    while (free_head < SLOTS) push_item(random_item(90, 0, 4));
    repeat (30) push_item(random_item(25, 0, 10));
    wait_drained();

    repeat (80) push_item(random_item(30, 30, 10));
    wait_drained();
    repeat (40) @(negedge clk_i);

    if (errors == 0)
      $display("PASS process_handle_table_unit");
    else
      $display("FAIL process_handle_table_unit");
    $finish;
  end

  initial begin
    #15_000_000;
    $display("FAIL process_handle_table_unit");
    $finish;
  end

endmodule

`default_nettype wire
